### design/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared definitions of the push-button press classifier
// Register indexes, reset values, field widths and the pipeline word type.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Configuration register widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXPIRE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHORT      = 3'd4;

  // Register reset values
  localparam logic [9:0] LONG_PRESS_RST = 10'd80;
  localparam logic [7:0] REPEAT_RST     = 8'd30;
  localparam logic [7:0] DEBOUNCE_RST   = 8'd10;
  localparam logic [9:0] EXPIRE_RST     = 10'd250;
  localparam logic [9:0] SHORT_RST      = 10'd30;

  // State constants
  localparam logic [7:0]  HOLDOFF_RST  = 8'd10;
  localparam logic [15:0] HOLD_MAX     = 16'hFFFF;
  localparam logic [3:0]  COLOUR_STEPS = 4'd10;

  // Word carried down the repeat-check pipeline
  typedef struct packed {
    logic        adj_direct;   // adjust event from a short release
    logic        chk;          // repeat event if remainder is zero
    logic [15:0] dividend;     // hold - long - 1, bits still to reduce
    logic [7:0]  rem;          // partial remainder
    logic [7:0]  period;       // repeat period captured with the word
    logic        upd;
    logic [2:0]  csel;
    logic        inv;
    logic        mode;
  } ppc_word_t;

endpackage

### design/ppc_in_if.sv
// ----------------------------------------------------------------------------
// ppc_in_if: input channel of the press classifier
// One word per tick: the sampled button level.
// ----------------------------------------------------------------------------
interface ppc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

### design/ppc_out_if.sv
// ----------------------------------------------------------------------------
// ppc_out_if: result channel of the press classifier
// One word per tick: adjust/colour pulses, colour selection and mode.
// ----------------------------------------------------------------------------
interface ppc_out_if;
  logic       valid;
  logic       ready;
  logic       adjust_event;
  logic       colour_update;
  logic [2:0] colour_select;
  logic       invert_select;
  logic       adjust_mode;

  modport source (output valid, output adjust_event, output colour_update,
                  output colour_select, output invert_select, output adjust_mode,
                  input ready);
  modport sink   (input valid, input adjust_event, input colour_update,
                  input colour_select, input invert_select, input adjust_mode,
                  output ready);
endinterface

### design/pushbutton_press_classifier_core.sv
// ----------------------------------------------------------------------------
// pushbutton_press_classifier_core: debounce, long press and auto-repeat
// Classifies one push button, one tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one word per tick with the sampled pin (0 pressed). Each
//   accepted word yields exactly one result word on out_if: adjust and colour
//   pulses, the colour step selection and the mode after that tick.
//   The cfg port writes one register per cycle (index, data); write only
//   while no word is in flight.
// Throughput and pipeline:
//   One word per cycle while out_if takes results. The button state updates at
//   acceptance, then the auto-repeat remainder (hold - long - 1) mod repeat
//   period is reduced 8 dividend bits per stage over two stages into the
//   output register.
// Reset:
//   Registers take their default values, holdoff starts at 10 ticks, the
//   pipeline empties and the block is in colour mode.
// Stall:
//   Each stage holds its word while the next one is full and cannot move on;
//   input ready drops only once all three stages are occupied and out_if.ready is low.
// ----------------------------------------------------------------------------
module pushbutton_press_classifier_core
  import ppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  ppc_in_if.sink              in_if,
  ppc_out_if.source           out_if
);

  // Eight restoring remainder steps over the next eight dividend bits
  function automatic logic [7:0] rem_step8(input logic [7:0] rem_in,
                                           input logic [7:0] bits,
                                           input logic [7:0] period);
    logic [8:0] t;
    logic [7:0] r;
    r = rem_in;
    for (int i = 7; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, period}) begin
        t = t - {1'b0, period};
      end
      r = t[7:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [9:0] long_q, expire_q, short_q;
  logic [7:0] repeat_q, debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q     <= LONG_PRESS_RST;
      repeat_q   <= REPEAT_RST;
      debounce_q <= DEBOUNCE_RST;
      expire_q   <= EXPIRE_RST;
      short_q    <= SHORT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LONG_PRESS: long_q     <= cfg_wdata_i;
        CFG_REPEAT:     repeat_q   <= cfg_wdata_i[7:0];
        CFG_DEBOUNCE:   debounce_q <= cfg_wdata_i[7:0];
        CFG_EXPIRE:     expire_q   <= cfg_wdata_i;
        CFG_SHORT:      short_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Button state
  logic [7:0]  holdoff_q, holdoff_d;
  logic [15:0] hold_q, hold_d;
  logic        mode_q, mode_d;
  logic [9:0]  expiry_q, expiry_d;
  logic [3:0]  step_q, step_d;
  logic        prev_q, prev_d;

  // Pipeline stages
  logic      s1_valid_q, s2_valid_q, out_valid_q;
  ppc_word_t s1_q, s2_q, s1_d, s2_d;
  logic      out_adj_q, out_upd_q, out_inv_q, out_mode_q;
  logic [2:0] out_csel_q;
  logic      out_rdy, s2_rdy, s1_rdy, in_acc;

  assign out_rdy = !out_valid_q || out_if.ready;
  assign s2_rdy  = !s2_valid_q || out_rdy;
  assign s1_rdy  = !s1_valid_q || s2_rdy;
  assign in_acc  = in_if.valid && s1_rdy;
  assign in_if.ready = s1_rdy;

  // Per-tick state update
  always_comb begin
    logic       lvl, adv;
    logic [3:0] s;
    logic [3:0] s_inc;
    lvl = in_if.button_level;
    holdoff_d = holdoff_q;
    hold_d    = hold_q;
    mode_d    = mode_q;
    expiry_d  = expiry_q;
    step_d    = step_q;
    prev_d    = prev_q;
    s1_d      = '0;
    adv       = 1'b0;
    s         = (step_q < COLOUR_STEPS) ? step_q : 4'd0;
    s_inc     = s + 4'd1;
    s1_d.period = repeat_q;

    if (holdoff_q != 8'd0) begin
      holdoff_d = holdoff_q - 8'd1;
    end else begin
      if (!lvl) begin
        // Pressed: count, enter adjust mode past the long-press limit
        adv    = (hold_q < HOLD_MAX);
        hold_d = hold_q + {15'd0, adv};
        if (hold_d > {6'd0, long_q}) begin
          mode_d   = 1'b1;
          expiry_d = expire_q;
          s1_d.chk = adv && (repeat_q > 8'd1);
          s1_d.dividend = hold_d - {6'd0, long_q} - 16'd1;
        end
      end else if (hold_q != 16'd0) begin
        // Release: short press steps colour or raises an adjust event
        if (hold_q < {6'd0, short_q}) begin
          if (mode_q) begin
            s1_d.adj_direct = 1'b1;
          end else begin
            s1_d.upd  = 1'b1;
            s1_d.csel = s[3:1];
            s1_d.inv  = s[0];
            step_d    = (s_inc >= COLOUR_STEPS) ? 4'd0 : s_inc;
          end
        end
        hold_d = '0;
      end

      // Adjust mode lifetime
      if (mode_d && expiry_d != 10'd0) begin
        expiry_d = expiry_d - 10'd1;
        if (expiry_d == 10'd0) begin
          mode_d = 1'b0;
        end
      end

      // Level change starts a holdoff
      if (lvl != prev_q) begin
        prev_d    = lvl;
        holdoff_d = debounce_q;
      end
    end
    s1_d.mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= HOLDOFF_RST;
      hold_q    <= '0;
      mode_q    <= 1'b0;
      expiry_q  <= '0;
      step_q    <= '0;
      prev_q    <= 1'b1;
    end else if (in_acc) begin
      holdoff_q <= holdoff_d;
      hold_q    <= hold_d;
      mode_q    <= mode_d;
      expiry_q  <= expiry_d;
      step_q    <= step_d;
      prev_q    <= prev_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_q  <= in_if.valid;
      if (s2_rdy)  s2_valid_q  <= s1_valid_q;
      if (out_rdy) out_valid_q <= s2_valid_q;
    end
  end

  // Stage two word: upper remainder bits reduced
  always_comb begin
    s2_d     = s1_q;
    s2_d.rem = rem_step8(8'd0, s1_q.dividend[15:8], s1_q.period);
  end

  // Payload: upper remainder bits in stage two, lower bits into the output
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s2_rdy && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (out_rdy && s2_valid_q) begin
      out_adj_q  <= s2_q.adj_direct ||
                    (s2_q.chk &&
                     (rem_step8(s2_q.rem, s2_q.dividend[7:0], s2_q.period) == 8'd0));
      out_upd_q  <= s2_q.upd;
      out_csel_q <= s2_q.csel;
      out_inv_q  <= s2_q.inv;
      out_mode_q <= s2_q.mode;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.adjust_event  = out_adj_q;
  assign out_if.colour_update = out_upd_q;
  assign out_if.colour_select = out_csel_q;
  assign out_if.invert_select = out_inv_q;
  assign out_if.adjust_mode   = out_mode_q;

endmodule
